### rtl/core/nalspl_pkg.sv
`default_nettype none
package nalspl_pkg;

  localparam int unsigned HoldDepth  = 4;
  localparam int unsigned QueueDepth = 4;
  localparam logic [7:0]  ZeroByte   = 8'h00;
  localparam logic [7:0]  StartByte  = 8'h01;
  localparam logic [2:0]  HoldFull   = 3'd4;
  localparam logic [2:0]  CountSat   = 3'd4;

  typedef struct packed {
    logic       run_end;
    logic       nal_last;
    logic       nal_first;
    logic [7:0] nal_byte;
  } nal_res_t;

  typedef struct packed {
    logic [1:0] num;
    nal_res_t   res0;
    nal_res_t   res1;
  } nal_push_t;

endpackage
`default_nettype wire

### rtl/core/nalspl_out_queue.sv
`default_nettype none
module nalspl_out_queue
  import nalspl_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire nal_push_t push,
  output logic           room,
  output logic           out_tvalid,
  input  wire logic      out_tready,
  output nal_res_t       out_res
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(DEPTH - 1);
  localparam logic [CW-1:0] RoomLimit = CW'(DEPTH - 2);

  nal_res_t      mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] wr_ptr_p1;
  logic          pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LastPtr) ? '0 : p + PW'(1);
  endfunction

  assign out_tvalid = (count_r != '0);
  assign out_res    = mem_r[rd_ptr_r];
  assign pop        = out_tvalid && out_tready;
  assign room       = (count_r <= RoomLimit);
  assign wr_ptr_p1  = ptr_inc(wr_ptr_r);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push.num == 2'd1) begin
      wr_ptr_nxt = wr_ptr_p1;
    end else if (push.num == 2'd2) begin
      wr_ptr_nxt = ptr_inc(wr_ptr_p1);
    end
    if (pop) begin
      rd_ptr_nxt = ptr_inc(rd_ptr_r);
    end
    count_nxt = count_r + CW'(push.num) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_ptr_r] <= push.res0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_ptr_p1] <= push.res1;
    end
  end

endmodule
`default_nettype wire

### rtl/core/h264_annexb_nal_splitter_unit.sv
// Each result beat is written into the result queue as its input beat is accepted and is offered from there.
// Throughput: one input beat per cycle while in_tready is high; a start code may produce two result beats.
// Input readiness is set by the four-entry result queue: in_tready is high while
// at least two queue entries are free, so a stalled output side throttles the input.
// Reset (rst_n low, synchronous) clears the hold-back bytes, counters and the queue.
`default_nettype none
module h264_annexb_nal_splitter_unit
  import nalspl_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] stream_byte
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,  // [7:0] nal_byte
  output logic            out_tlast,  // nal_last
  output logic [1:0]      out_tuser   // [0] nal_first, [1] run_end
);

  logic [7:0] hold_r [HoldDepth];
  logic [7:0] hold_nxt [HoldDepth];
  logic [2:0] hold_count_r, hold_count_nxt;
  logic [2:0] nal_count_r, nal_count_nxt;
  logic       in_nal_r, in_nal_nxt;
  logic       header_due_r, header_due_nxt;
  logic       accept;
  logic       code;
  logic       room;
  nal_push_t  push;
  nal_res_t   out_res;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = room;
  assign code      = (in_tdata == StartByte) && (hold_r[0] == ZeroByte) &&
                     (hold_r[1] == ZeroByte);

  always_comb begin
    for (int k = 0; k < HoldDepth; k++) begin
      hold_nxt[k] = hold_r[k];
    end
    hold_count_nxt = hold_count_r;
    nal_count_nxt  = nal_count_r;
    in_nal_nxt     = in_nal_r;
    header_due_nxt = header_due_r;
    push           = '0;
    if (accept) begin
      hold_nxt[0] = in_tdata;
      for (int k = 1; k < HoldDepth; k++) begin
        hold_nxt[k] = hold_r[k-1];
      end
      if (!in_nal_r) begin
        if (code && (nal_count_r >= 3'd2)) begin
          in_nal_nxt     = 1'b1;
          header_due_nxt = 1'b1;
          nal_count_nxt  = '0;
          hold_count_nxt = '0;
        end else if (nal_count_r < CountSat) begin
          nal_count_nxt = nal_count_r + 3'd1;
        end
      end else if (code && (nal_count_r >= 3'd3)) begin
        if (hold_count_r >= HoldFull) begin
          if (hold_r[2] == ZeroByte) begin
            push.num  = 2'd1;
            push.res0 = '{run_end: 1'b1, nal_last: 1'b1, nal_first: header_due_r,
                          nal_byte: hold_r[3]};
          end else begin
            push.num  = 2'd2;
            push.res0 = '{run_end: 1'b0, nal_last: 1'b0, nal_first: header_due_r,
                          nal_byte: hold_r[3]};
            push.res1 = '{run_end: 1'b1, nal_last: 1'b1, nal_first: 1'b0,
                          nal_byte: hold_r[2]};
          end
        end else if ((hold_count_r == 3'd3) && (hold_r[2] != ZeroByte)) begin
          push.num  = 2'd1;
          push.res0 = '{run_end: 1'b1, nal_last: 1'b1, nal_first: header_due_r,
                        nal_byte: hold_r[2]};
        end
        header_due_nxt = 1'b1;
        nal_count_nxt  = '0;
        hold_count_nxt = '0;
      end else begin
        if (hold_count_r >= HoldFull) begin
          push.num       = 2'd1;
          push.res0      = '{run_end: 1'b1, nal_last: 1'b0, nal_first: header_due_r,
                             nal_byte: hold_r[3]};
          header_due_nxt = 1'b0;
          hold_count_nxt = HoldFull;
        end else begin
          hold_count_nxt = hold_count_r + 3'd1;
        end
        if (nal_count_r < CountSat) begin
          nal_count_nxt = nal_count_r + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < HoldDepth; k++) begin
        hold_r[k] <= '0;
      end
      hold_count_r <= '0;
      nal_count_r  <= '0;
      in_nal_r     <= 1'b0;
      header_due_r <= 1'b0;
    end else begin
      for (int k = 0; k < HoldDepth; k++) begin
        hold_r[k] <= hold_nxt[k];
      end
      hold_count_r <= hold_count_nxt;
      nal_count_r  <= nal_count_nxt;
      in_nal_r     <= in_nal_nxt;
      header_due_r <= header_due_nxt;
    end
  end

  nalspl_out_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = out_res.nal_byte;
  assign out_tlast = out_res.nal_last;
  assign out_tuser = {out_res.run_end, out_res.nal_first};

endmodule
`default_nettype wire

### tb/tb_h264_annexb_nal_splitter_unit.sv
`timescale 1ns / 100ps

class nal_scoreboard;
  logic [7:0] held [4];
  logic [2:0] held_cnt;
  logic [2:0] since_code;
  logic       in_nal;
  logic       header_due;
  nalspl_pkg::nal_res_t nal_beats_due[$];
  int unsigned mismatches;

  function new();
    foreach (held[i]) held[i] = nalspl_pkg::ZeroByte;
    held_cnt   = '0;
    since_code = '0;
    in_nal     = 1'b0;
    header_due = 1'b0;
    mismatches = 0;
  endfunction

  function void shift_held(logic [7:0] b);
    held[3] = held[2];
    held[2] = held[1];
    held[1] = held[0];
    held[0] = b;
  endfunction

  function void push_beat(logic [7:0] b, logic last);
    nalspl_pkg::nal_res_t r;
    r.nal_byte  = b;
    r.nal_first = header_due;
    r.nal_last  = last;
    r.run_end   = 1'b0;
    header_due  = 1'b0;
    nal_beats_due.push_back(r);
  endfunction

  function void split_byte(logic [7:0] b);
    logic is_code;
    int   top;
    int   lowest;
    int   n;
    is_code = (b == nalspl_pkg::StartByte) && (held[0] == nalspl_pkg::ZeroByte)
              && (held[1] == nalspl_pkg::ZeroByte);
    n = 0;
    if (!in_nal) begin
      if (is_code && since_code >= 3'd2) begin
        in_nal     = 1'b1;
        header_due = 1'b1;
        since_code = '0;
        held_cnt   = '0;
      end else if (since_code < nalspl_pkg::CountSat) begin
        since_code++;
      end
      shift_held(b);
      return;
    end
    if (is_code && since_code >= 3'd3) begin
      top    = int'(held_cnt) - 1;
      lowest = 2;
      if (top > 3) top = 3;
      if (top >= 2 && held[2] == nalspl_pkg::ZeroByte) lowest = 3;
      for (int i = top; i >= lowest; i--) begin
        push_beat(held[i], i == lowest);
        n++;
      end
      header_due = 1'b1;
      since_code = '0;
      held_cnt   = '0;
      shift_held(b);
    end else begin
      if (held_cnt >= nalspl_pkg::HoldFull) begin
        push_beat(held[3], 1'b0);
        n++;
      end else begin
        held_cnt++;
      end
      shift_held(b);
      if (since_code < nalspl_pkg::CountSat) since_code++;
    end
    if (n > 0) nal_beats_due[nal_beats_due.size() - 1].run_end = 1'b1;
  endfunction

  task report(string what);
    mismatches++;
    if (mismatches <= 100) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task check_nal_beat(logic [7:0] d, logic last, logic [1:0] user);
    nalspl_pkg::nal_res_t want;
    if (nal_beats_due.size() == 0) begin
      report($sformatf("unexpected beat byte=%02h last=%b user=%b", d, last, user));
      return;
    end
    want = nal_beats_due.pop_front();
    if (d !== want.nal_byte || last !== want.nal_last || user[0] !== want.nal_first
        || user[1] !== want.run_end) begin
      report($sformatf("byte %02h/%02h first %b/%b last %b/%b run_end %b/%b (got/exp)",
                       d, want.nal_byte, user[0], want.nal_first, last, want.nal_last,
                       user[1], want.run_end));
    end
  endtask

  function int unsigned pending();
    return nal_beats_due.size();
  endfunction
endclass

module tb_h264_annexb_nal_splitter_unit;
  import nalspl_pkg::*;

  localparam int unsigned StallLimit = 3000;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [1:0] out_tuser;

  nal_scoreboard sb = new();
  logic [7:0]    stream_q[$];
  int unsigned   bytes_taken;
  int unsigned   beats_seen;
  int unsigned   quiet_cycles;

  h264_annexb_nal_splitter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] biased_byte();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick < 2) return ZeroByte;
    if (pick == 2) return StartByte;
    return 8'($urandom_range(0, 255));
  endfunction

  task build_stream();
    int unsigned len;
    stream_q = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h01,
                 8'h00, 8'h00, 8'h01, 8'hff, 8'h00, 8'h00, 8'h01,
                 8'h00, 8'h00, 8'h00, 8'h01,
                 8'h80, 8'h00, 8'h00, 8'h01,
                 8'h7f, 8'hff, 8'h00, 8'h00, 8'h00, 8'h01};
    while (stream_q.size() < 1626) begin
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 2) == 0) stream_q.push_back(ZeroByte);
        stream_q.push_back(ZeroByte);
        stream_q.push_back(ZeroByte);
        stream_q.push_back(StartByte);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        repeat (len) begin
          stream_q.push_back($urandom_range(0, 1) ? biased_byte() : 8'($urandom_range(0, 255)));
        end
      end else begin
        repeat ($urandom_range(1, 8)) stream_q.push_back(biased_byte());
      end
    end
  endtask

  task send_byte(logic [7:0] b, logic calm);
    while (!calm && $urandom_range(0, 99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    rst_n     <= 1'b0;
    build_stream();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (stream_q[i]) send_byte(stream_q[i], i >= 900 && i < 1200);
    in_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int unsigned hold_left;
    logic        pressure_done;
    hold_left     = 0;
    pressure_done = 1'b0;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!pressure_done && bytes_taken >= 400) begin
        pressure_done = 1'b1;
        hold_left     = 300;
        out_tready <= 1'b0;
      end else begin
        out_tready <= (beats_seen >= 500 && beats_seen < 800) || ($urandom_range(0, 99) >= 25);
      end
      @(posedge clk);
    end
  end

  initial begin
    bytes_taken  = 0;
    beats_seen   = 0;
    quiet_cycles = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.split_byte(in_tdata);
        bytes_taken++;
      end
      if (out_tvalid && out_tready) begin
        sb.check_nal_beat(out_tdata, out_tlast, out_tuser);
        beats_seen++;
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

endmodule

### filelist.f
rtl/core/nalspl_pkg.sv
rtl/core/nalspl_out_queue.sv
rtl/core/h264_annexb_nal_splitter_unit.sv
tb/tb_h264_annexb_nal_splitter_unit.sv
